/* src/pel_pkg.sv */
`timescale 1ns / 1ps
// pel_pkg: shared constants, types and codes of the peak envelope line decimator.
// No dependencies; imported by every module under src.
package pel_pkg;

    localparam int DEF_MAX_SAMPLES = 1048576;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int LINE_STRIDE     = 3;
    localparam int RUN_CAP         = 64;
    localparam int RUN_CNT_BITS    = 7;
    localparam int QUEUE_DEPTH     = 4;

    localparam int NS_BITS         = 21;
    localparam int LINE_BITS       = 12;
    localparam int HH_BITS         = 11;
    localparam int COORD_BITS      = 12;
    localparam int X_BITS          = 14;
    localparam int Y_BITS          = 13;
    localparam int CFG_DATA_BITS   = 21;
    localparam int CFG_INDEX_BITS  = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_NUM_SAMPLES = 3'd0,
        CFG_NUM_LINES   = 3'd1,
        CFG_HALF_HEIGHT = 3'd2,
        CFG_CENTER_Y    = 3'd3,
        CFG_X_ORIGIN    = 3'd4
    } t_cfg_index;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_RUN
    } t_back_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    typedef struct packed {
        logic [LINE_BITS-1:0]  num_lines;
        logic [HH_BITS-1:0]    half_height;
        logic [COORD_BITS-1:0] center_y;
        logic [COORD_BITS-1:0] x_origin;
    } t_draw_cfg;

endpackage

/* src/pel_front.sv */
`timescale 1ns / 1ps
// pel_front: input word acceptance, sample magnitude, short queue to the back end.
// Depends on pel_pkg.
module pel_front #(
    parameter int SAMPLE_BITS = pel_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_hold,
    input  logic                          i_in_valid,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_in_stall,
    output logic                          o_mag_valid,
    output logic [SAMPLE_BITS-1:0]        o_mag,
    input  logic                          i_pop
);
    import pel_pkg::*;

    localparam int QB = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [SAMPLE_BITS-1:0] r_q [QUEUE_DEPTH];
    logic [QB-1:0]          r_wr, r_rd;
    logic [QB:0]            r_cnt;
    logic [SAMPLE_BITS-1:0] raw, mag;
    logic                   push, full;

    assign raw  = i_sample;
    // two's complement magnitude; the most negative code maps to 2^(SAMPLE_BITS-1)
    assign mag  = raw[SAMPLE_BITS-1] ? SAMPLE_BITS'(~raw + 1'b1) : raw;
    assign full = (r_cnt == (QB+1)'(QUEUE_DEPTH));
    assign o_in_stall  = i_hold || full;
    assign push        = i_in_valid && !o_in_stall;
    assign o_mag_valid = (r_cnt != '0);
    assign o_mag       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == QB'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == QB'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QB+1)'(push) - (QB+1)'(i_pop);
        end
    end

endmodule

/* src/pel_div.sv */
`timescale 1ns / 1ps
// pel_div: restoring divider, one quotient bit per cycle, for samples / lines.
// Depends on pel_pkg.
module pel_div #(
    parameter int NB = 21
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [NB-1:0]                  i_dividend,
    input  logic [pel_pkg::LINE_BITS-1:0]  i_divisor,
    output logic [NB-1:0]                  o_quo,
    output logic [pel_pkg::LINE_BITS-1:0]  o_rem,
    output pel_pkg::t_div_status           o_status
);
    import pel_pkg::*;

    localparam int CB = $clog2(NB + 1);

    logic [NB-1:0]        r_quo;
    logic [LINE_BITS-1:0] r_rem, r_div;
    logic [CB-1:0]        r_cnt;
    logic                 r_busy, r_done;
    logic [LINE_BITS:0]   shifted, diff;
    logic                 qbit;

    assign shifted = {r_rem, r_quo[NB-1]};
    assign qbit    = (shifted >= {1'b0, r_div});
    assign diff    = shifted - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= NB'({r_quo, qbit});
            r_rem <= qbit ? diff[LINE_BITS-1:0] : shifted[LINE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CB'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CB'(NB);
            end else if (r_busy) begin
                r_cnt  <= r_cnt - 1'b1;
                r_busy <= (r_cnt != CB'(1));
            end
        end
    end

    assign o_quo         = r_quo;
    assign o_rem         = r_rem;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

endmodule

/* src/pel_back.sv */
`timescale 1ns / 1ps
// pel_back: bucket tracking, line run sequencing and the output word register.
// Depends on pel_pkg; takes magnitudes from pel_front and the quotient from pel_div.
module pel_back #(
    parameter int SAMPLE_BITS = pel_pkg::DEF_SAMPLE_BITS,
    parameter int NB          = 21
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_restart,
    input  pel_pkg::t_draw_cfg             i_cfg,
    input  logic [NB-1:0]                  i_eff_n,
    input  logic [NB-1:0]                  i_quo,
    input  logic [pel_pkg::LINE_BITS-1:0]  i_rem,
    input  logic                           i_mag_valid,
    input  logic [SAMPLE_BITS-1:0]         i_mag,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [pel_pkg::LINE_BITS-1:0]  o_line_index,
    output logic [pel_pkg::X_BITS-1:0]     o_line_x,
    output logic [SAMPLE_BITS-1:0]         o_peak,
    output logic signed [pel_pkg::Y_BITS-1:0] o_y_top,
    output logic [pel_pkg::Y_BITS-1:0]     o_y_bottom,
    output logic                           o_last_of_run,
    output logic                           o_frame_done
);
    import pel_pkg::*;

    localparam int PB = SAMPLE_BITS + HH_BITS;

    t_back_state r_state, n_state;

    logic [NB-1:0]           r_count, n_count, r_pos, n_pos;
    logic [LINE_BITS-1:0]    r_line, n_line, r_pend_idx, n_pend_idx;
    logic [SAMPLE_BITS-1:0]  r_peak, n_peak;
    logic [HH_BITS-1:0]      r_half, n_half;
    logic [NB:0]             r_start, n_start, r_end, n_end;
    logic [LINE_BITS-1:0]    r_brem, n_brem;
    logic                    r_carry, n_carry;
    logic [RUN_CNT_BITS-1:0] r_emit_cnt, n_emit_cnt;
    logic                    r_hit_last, n_hit_last, r_closed, n_closed;
    logic                    r_have_pend, n_have_pend;

    logic                    r_out_valid, n_out_valid;
    logic [LINE_BITS-1:0]    r_o_idx, n_o_idx;
    logic [X_BITS-1:0]       r_o_x, n_o_x;
    logic [SAMPLE_BITS-1:0]  r_o_peak, n_o_peak;
    logic [Y_BITS-1:0]       r_o_top, n_o_top, r_o_bot, n_o_bot;
    logic                    r_o_last, n_o_last, r_o_done, n_o_done;

    logic                    run_hit, emit_now, out_free, step_go, run_end;
    logic                    push_mid, push_last, do_restart;
    logic [PB-1:0]           product;
    logic [LINE_BITS:0]      sum, sum2;
    logic [LINE_BITS-1:0]    adv_rem;
    logic                    adv_carry;
    logic [NB:0]             adv_start, adv_end, end0;

    assign run_hit   = (r_line < i_cfg.num_lines) && (r_end <= {1'b0, r_pos});
    assign emit_now  = (r_emit_cnt < RUN_CNT_BITS'(RUN_CAP));
    assign out_free  = !r_out_valid || !i_out_stall;
    assign step_go   = (r_state == BK_RUN) && run_hit
                       && (!(emit_now && r_have_pend) || out_free);
    assign run_end   = (r_state == BK_RUN) && !run_hit && (!r_have_pend || out_free);
    assign push_mid  = step_go && emit_now && r_have_pend;
    assign push_last = run_end && r_have_pend;
    assign o_pop     = (r_state == BK_IDLE) && i_mag_valid && !i_restart;
    assign do_restart = i_restart || (run_end && (r_pos >= i_eff_n));

    assign product = PB'(r_peak) * PB'(i_cfg.half_height);

    // bucket bounds: start += q + carry, remainder wraps at num_lines
    assign sum       = {1'b0, r_brem} + {1'b0, i_rem};
    assign adv_rem   = r_carry ? LINE_BITS'(sum - {1'b0, i_cfg.num_lines})
                               : sum[LINE_BITS-1:0];
    assign sum2      = {1'b0, adv_rem} + {1'b0, i_rem};
    assign adv_carry = (sum2 >= {1'b0, i_cfg.num_lines});
    assign adv_start = r_start + {1'b0, i_quo} + (NB+1)'(r_carry);
    assign adv_end   = adv_start + ((i_quo == '0) ? (NB+1)'(1)
                                                  : {1'b0, i_quo} + (NB+1)'(adv_carry));
    assign end0      = (i_quo == '0) ? (NB+1)'(1) : {1'b0, i_quo};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (o_pop) n_state = BK_MUL;
            end
            BK_MUL: begin
                n_state = BK_RUN;
            end
            BK_RUN: begin
                if (run_end) n_state = BK_IDLE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_pos       = r_pos;
        n_line      = r_line;
        n_pend_idx  = r_pend_idx;
        n_peak      = r_peak;
        n_half      = r_half;
        n_start     = r_start;
        n_end       = r_end;
        n_brem      = r_brem;
        n_carry     = r_carry;
        n_emit_cnt  = r_emit_cnt;
        n_hit_last  = r_hit_last;
        n_closed    = r_closed;
        n_have_pend = r_have_pend;

        unique case (r_state)
            BK_IDLE: begin
                if (o_pop) begin
                    n_peak = (i_mag > r_peak) ? i_mag : r_peak;
                    n_pos  = r_count + 1'b1;
                end
            end
            BK_MUL: begin
                n_half      = product[SAMPLE_BITS-1 +: HH_BITS];
                n_emit_cnt  = '0;
                n_hit_last  = 1'b0;
                n_closed    = 1'b0;
                n_have_pend = 1'b0;
            end
            BK_RUN: begin
                if (step_go) begin
                    if (emit_now) begin
                        n_pend_idx  = r_line;
                        n_have_pend = 1'b1;
                        n_emit_cnt  = r_emit_cnt + 1'b1;
                    end
                    if (r_line == i_cfg.num_lines - 1'b1) n_hit_last = 1'b1;
                    n_closed = 1'b1;
                    n_line   = r_line + 1'b1;
                    n_start  = adv_start;
                    n_brem   = adv_rem;
                    n_carry  = adv_carry;
                    n_end    = adv_end;
                end
                if (run_end) begin
                    n_have_pend = 1'b0;
                    if (r_closed) n_peak = '0;
                    n_count = r_pos;
                end
            end
            default: begin
            end
        endcase

        if (do_restart) begin
            n_count = '0;
            n_line  = '0;
            n_peak  = '0;
            n_start = '0;
            n_brem  = '0;
            n_carry = 1'b0;
            n_end   = end0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_o_idx     = r_o_idx;
        n_o_x       = r_o_x;
        n_o_peak    = r_o_peak;
        n_o_top     = r_o_top;
        n_o_bot     = r_o_bot;
        n_o_last    = r_o_last;
        n_o_done    = r_o_done;
        if (push_mid || push_last) begin
            n_out_valid = 1'b1;
            n_o_idx     = r_pend_idx;
            n_o_x       = X_BITS'(i_cfg.x_origin) + X_BITS'(LINE_STRIDE * r_pend_idx);
            n_o_peak    = r_peak;
            n_o_top     = Y_BITS'(i_cfg.center_y) - Y_BITS'(r_half);
            n_o_bot     = Y_BITS'(i_cfg.center_y) + Y_BITS'(r_half);
            n_o_last    = push_last;
            n_o_done    = push_last && r_hit_last;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_count     <= '0;
            r_pos       <= '0;
            r_line      <= '0;
            r_peak      <= '0;
            r_start     <= '0;
            r_end       <= (NB+1)'(1);
            r_brem      <= '0;
            r_carry     <= 1'b0;
            r_emit_cnt  <= '0;
            r_hit_last  <= 1'b0;
            r_closed    <= 1'b0;
            r_have_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_line      <= n_line;
            r_peak      <= n_peak;
            r_start     <= n_start;
            r_end       <= n_end;
            r_brem      <= n_brem;
            r_carry     <= n_carry;
            r_emit_cnt  <= n_emit_cnt;
            r_hit_last  <= n_hit_last;
            r_closed    <= n_closed;
            r_have_pend <= n_have_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_half     <= n_half;
        r_pend_idx <= n_pend_idx;
        r_o_idx    <= n_o_idx;
        r_o_x      <= n_o_x;
        r_o_peak   <= n_o_peak;
        r_o_top    <= n_o_top;
        r_o_bot    <= n_o_bot;
        r_o_last   <= n_o_last;
        r_o_done   <= n_o_done;
    end

    assign o_out_valid   = r_out_valid;
    assign o_line_index  = r_o_idx;
    assign o_line_x      = r_o_x;
    assign o_peak        = r_o_peak;
    assign o_y_top       = r_o_top;
    assign o_y_bottom    = r_o_bot;
    assign o_last_of_run = r_o_last;
    assign o_frame_done  = r_o_done;

endmodule

/* src/peak_envelope_line_decimator.sv */
`timescale 1ns / 1ps
// Peak envelope line decimator: samples in, one vertical line word per closed bucket out
// (at most 64 per sample, the rest skipped); a sample is queued, popped, scaled and run.
// A sample holds the back end while it closes its lines (emitted or skipped); the 4-word
// queue lets the input run ahead meanwhile.
// Reset (synchronous, active low) and each write to a defined register start a frame over;
// input then stalls while the bucket quotient is divided out bit by bit.
module peak_envelope_line_decimator #(
    parameter int MAX_SAMPLES = pel_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = pel_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [pel_pkg::CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic [pel_pkg::CFG_DATA_BITS-1:0]      i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]          i_sample,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [pel_pkg::LINE_BITS-1:0]          o_line_index,
    output logic [pel_pkg::X_BITS-1:0]             o_line_x,
    output logic [SAMPLE_BITS-1:0]                 o_peak,
    output logic signed [pel_pkg::Y_BITS-1:0]      o_y_top,
    output logic [pel_pkg::Y_BITS-1:0]             o_y_bottom,
    output logic                                   o_last_of_run,
    output logic                                   o_frame_done
);
    import pel_pkg::*;

    localparam int NB = $clog2(MAX_SAMPLES + 1);
    localparam int CW = (NB > NS_BITS) ? NB : NS_BITS;

    logic [NS_BITS-1:0]    r_num_samples;
    logic [LINE_BITS-1:0]  r_num_lines;
    logic [HH_BITS-1:0]    r_half_height;
    logic [COORD_BITS-1:0] r_center_y;
    logic [COORD_BITS-1:0] r_x_origin;
    logic                  r_kick;
    logic                  cfg_known;

    logic [CW-1:0]         ns_w;
    logic [NB-1:0]         eff_n, quo;
    logic [LINE_BITS-1:0]  rem;
    t_div_status           div_status;
    t_draw_cfg             draw_cfg;
    logic                  mag_valid, pop;
    logic [SAMPLE_BITS-1:0] mag;

    always_comb begin
        unique case (t_cfg_index'(i_cfg_index))
            CFG_NUM_SAMPLES, CFG_NUM_LINES, CFG_HALF_HEIGHT,
            CFG_CENTER_Y, CFG_X_ORIGIN: cfg_known = 1'b1;
            default:                    cfg_known = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_samples <= NS_BITS'(1);
            r_num_lines   <= '0;
            r_half_height <= '0;
            r_center_y    <= '0;
            r_x_origin    <= '0;
            r_kick        <= 1'b1;
        end else begin
            r_kick <= i_cfg_we && cfg_known;
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_NUM_SAMPLES: r_num_samples <= i_cfg_data[NS_BITS-1:0];
                    CFG_NUM_LINES:   r_num_lines   <= i_cfg_data[LINE_BITS-1:0];
                    CFG_HALF_HEIGHT: r_half_height <= i_cfg_data[HH_BITS-1:0];
                    CFG_CENTER_Y:    r_center_y    <= i_cfg_data[COORD_BITS-1:0];
                    CFG_X_ORIGIN:    r_x_origin    <= i_cfg_data[COORD_BITS-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign ns_w  = CW'(r_num_samples);
    assign eff_n = (r_num_samples == '0)        ? NB'(1) :
                   (ns_w > CW'(MAX_SAMPLES))    ? NB'(MAX_SAMPLES) : NB'(ns_w);

    assign draw_cfg.num_lines   = r_num_lines;
    assign draw_cfg.half_height = r_half_height;
    assign draw_cfg.center_y    = r_center_y;
    assign draw_cfg.x_origin    = r_x_origin;

    pel_div #(
        .NB (NB)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_kick),
        .i_dividend (eff_n),
        .i_divisor  (r_num_lines),
        .o_quo      (quo),
        .o_rem      (rem),
        .o_status   (div_status)
    );

    pel_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (r_kick || div_status.busy),
        .i_in_valid  (i_in_valid),
        .i_sample    (i_sample),
        .o_in_stall  (o_in_stall),
        .o_mag_valid (mag_valid),
        .o_mag       (mag),
        .i_pop       (pop)
    );

    pel_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .NB          (NB)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_restart     (div_status.done),
        .i_cfg         (draw_cfg),
        .i_eff_n       (eff_n),
        .i_quo         (quo),
        .i_rem         (rem),
        .i_mag_valid   (mag_valid),
        .i_mag         (mag),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_line_index  (o_line_index),
        .o_line_x      (o_line_x),
        .o_peak        (o_peak),
        .o_y_top       (o_y_top),
        .o_y_bottom    (o_y_bottom),
        .o_last_of_run (o_last_of_run),
        .o_frame_done  (o_frame_done)
    );

    a_cfg_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && cfg_known) |=> o_in_stall)
        else $error("input not held after a register write");

    a_kick_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kick |=> div_status.busy)
        else $error("quotient not recomputed after a register write");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_done) |-> o_last_of_run)
        else $error("frame end flagged on a word that does not end its run");

    a_peak_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_peak <= {1'b1, {(SAMPLE_BITS-1){1'b0}}}))
        else $error("peak above full scale");

endmodule

/* tb/sv/peak_envelope_line_decimator_tb.sv */
`timescale 1ns / 1ps
// peak_envelope_line_decimator_tb: self-checking bench that streams sample frames through the
// decimator and checks every line word against the bench's bucket and peak predictor or a hand-computed word.
// Depends on src/pel_pkg.sv and src/peak_envelope_line_decimator.sv.
module peak_envelope_line_decimator_tb;
    import pel_pkg::*;

    localparam int SBITS                    = DEF_SAMPLE_BITS;
    localparam int unsigned FRAME_CAP       = DEF_MAX_SAMPLES;
    localparam int unsigned LINES_TOP       = (1 << LINE_BITS) - 1;
    localparam int unsigned DRAIN_CYCLES    = 4400;
    localparam int unsigned CYCLE_LIMIT     = 1000000;
    localparam int unsigned RANDOM_ITEMS    = 210;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [CFG_DATA_BITS-1:0]  CFG_DATA_ALL = '1;

    typedef struct packed {
        logic [LINE_BITS-1:0]     index;
        logic [X_BITS-1:0]        x;
        logic [SBITS-1:0]         peak;
        logic signed [Y_BITS-1:0] top;
        logic [Y_BITS-1:0]        bottom;
        logic                     last;
        logic                     done;
    } line_word_t;

    typedef struct {
        bit                        is_cfg;
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [CFG_DATA_BITS-1:0]  data;
        logic signed [SBITS-1:0]   smp;
        bit                        typed;
        line_word_t                want;
    } stim_row_t;

    logic                        clk;
    logic                        rst_n     = 1'b0;
    logic                        cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0]   cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]    cfg_data  = '0;
    logic                        in_valid  = 1'b0;
    logic signed [SBITS-1:0]     sample    = '0;
    logic                        out_stall = 1'b0;
    logic                        in_stall;
    logic                        out_valid;
    logic [LINE_BITS-1:0]        line_index;
    logic [X_BITS-1:0]           line_x;
    logic [SBITS-1:0]            peak;
    logic signed [Y_BITS-1:0]    y_top;
    logic [Y_BITS-1:0]           y_bottom;
    logic                        last_of_run;
    logic                        frame_done;

    line_word_t  pending_lines[$];
    stim_row_t   dir_rows[$];
    int          errors  = 0;
    int unsigned cycles  = 0;
    bit          quiet   = 1'b0;
    bit          settled = 1'b0;

    // predictor copy of the registers and frame position
    logic [NS_BITS-1:0]    r_num_samples;
    logic [LINE_BITS-1:0]  r_num_lines;
    logic [HH_BITS-1:0]    r_half_height;
    logic [COORD_BITS-1:0] r_center_y;
    logic [COORD_BITS-1:0] r_x_origin;
    int unsigned f_count, f_line, f_peak, f_start, f_end, f_rem;

    peak_envelope_line_decimator u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_sample      (sample),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_line_index  (line_index),
        .o_line_x      (line_x),
        .o_peak        (peak),
        .o_y_top       (y_top),
        .o_y_bottom    (y_bottom),
        .o_last_of_run (last_of_run),
        .o_frame_done  (frame_done)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned frame_len();
        int unsigned n;
        n = r_num_samples;
        if (n == 0) n = 1;
        if (n > FRAME_CAP) n = FRAME_CAP;
        return n;
    endfunction

    function automatic int unsigned bucket_end_of(input int unsigned lo, input int unsigned rem);
        int unsigned n, l, hi;
        n = frame_len();
        l = r_num_lines;
        if (l == 0) return lo + 1;
        hi = lo + n / l + (((rem + n % l) >= l) ? 1 : 0);
        return (hi > lo + 1) ? hi : lo + 1;
    endfunction

    task automatic restart_frame();
        f_count = 0;
        f_line  = 0;
        f_peak  = 0;
        f_start = 0;
        f_rem   = 0;
        f_end   = bucket_end_of(0, 0);
    endtask

    task automatic predict_lines(input logic signed [SBITS-1:0] s, input bit keep);
        int          sv;
        int unsigned mag, l, n, pos, half, cnt, sum;
        bit          closed, hit_last;
        logic [31:0] top, bot;
        line_word_t  w;
        line_word_t  run[$];
        sv  = s;
        mag = (sv < 0) ? int'(-sv) : sv;
        if (mag > f_peak) f_peak = mag;
        l        = r_num_lines;
        n        = frame_len();
        pos      = f_count + 1;
        cnt      = 0;
        closed   = 1'b0;
        hit_last = 1'b0;
        while (f_line < l && f_end <= pos) begin
            if (cnt < RUN_CAP) begin
                half     = (f_peak * r_half_height) >> (SBITS - 1);
                top      = r_center_y - half;
                bot      = r_center_y + half;
                w.index  = f_line[LINE_BITS-1:0];
                w.x      = X_BITS'(r_x_origin + LINE_STRIDE * f_line);
                w.peak   = f_peak[SBITS-1:0];
                w.top    = top[Y_BITS-1:0];
                w.bottom = bot[Y_BITS-1:0];
                w.last   = 1'b0;
                w.done   = 1'b0;
                run.push_back(w);
                cnt++;
            end
            if (f_line + 1 == l) hit_last = 1'b1;
            closed = 1'b1;
            f_line++;
            // step to the next bucket with the remainder accumulator
            sum     = f_rem + n % l;
            f_start = f_start + n / l;
            if (sum >= l) begin
                sum     = sum - l;
                f_start = f_start + 1;
            end
            f_rem = sum;
            f_end = bucket_end_of(f_start, f_rem);
        end
        if (cnt > 0) begin
            w      = run.pop_back();
            w.last = 1'b1;
            w.done = hit_last;
            run.push_back(w);
        end
        if (closed) f_peak = 0;
        f_count++;
        if (f_count >= n) restart_frame();
        if (keep) begin
            foreach (run[i]) pending_lines.push_back(run[i]);
        end
    endtask

    function automatic logic [CFG_DATA_BITS-1:0] pick_field(input int bits);
        logic [CFG_DATA_BITS-1:0] top_v;
        top_v = (CFG_DATA_BITS'(1) << bits) - 1;
        case ($urandom_range(0, 3))
            0: return '0;
            1: return top_v;
            default: return CFG_DATA_BITS'($urandom) & top_v;
        endcase
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // writes only once nothing is in flight; the first write after a word drains the block
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        bit known;
        in_valid <= 1'b0;
        if (!settled) begin
            while (pending_lines.size() != 0) @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
            settled = 1'b1;
        end
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        known = 1'b1;
        case (idx)
            CFG_NUM_SAMPLES: r_num_samples = data[NS_BITS-1:0];
            CFG_NUM_LINES:   r_num_lines   = data[LINE_BITS-1:0];
            CFG_HALF_HEIGHT: r_half_height = data[HH_BITS-1:0];
            CFG_CENTER_Y:    r_center_y    = data[COORD_BITS-1:0];
            CFG_X_ORIGIN:    r_x_origin    = data[COORD_BITS-1:0];
            default:         known = 1'b0;
        endcase
        if (known) restart_frame();
    endtask

    task automatic send_sample(input logic signed [SBITS-1:0] s, input bit keep);
        if (!quiet && $urandom_range(0, 99) < 24) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        settled = 1'b0;
        predict_lines(s, keep);
    endtask

    task automatic run_phase(input logic [CFG_DATA_BITS-1:0] n, input logic [LINE_BITS-1:0] l,
                             input int unsigned items);
        logic signed [SBITS-1:0] s;
        write_reg(CFG_NUM_SAMPLES, n);
        write_reg(CFG_NUM_LINES, CFG_DATA_BITS'(l));
        write_reg(CFG_HALF_HEIGHT, pick_field(HH_BITS));
        write_reg(CFG_CENTER_Y, pick_field(COORD_BITS));
        write_reg(CFG_X_ORIGIN, pick_field(COORD_BITS));
        for (int k = 0; k < items; k++) begin
            // sender holds off until every pending line word is out
            if (k == items / 2 || $urandom_range(0, 39) == 0) begin
                in_valid <= 1'b0;
                do @(posedge clk); while (pending_lines.size() != 0);
            end
            case ($urandom_range(0, 7))
                0:       s = {1'b1, {(SBITS-1){1'b0}}};
                1:       s = {1'b0, {(SBITS-1){1'b1}}};
                2:       s = '0;
                3:       s = SBITS'(int'($urandom_range(0, 6)) - 3);
                default: s = SBITS'($urandom);
            endcase
            send_sample(s, 1'b1);
        end
    endtask

    task automatic add_cfg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
        stim_row_t r;
        r        = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        dir_rows.push_back(r);
    endtask

    task automatic add_sample(input logic signed [SBITS-1:0] s);
        stim_row_t r;
        r     = '{default: '0};
        r.smp = s;
        dir_rows.push_back(r);
    endtask

    // single-line frame with a hand-computed line word
    task automatic add_typed(input logic signed [SBITS-1:0] s, input int x, input int pk,
                             input int top, input int bot);
        stim_row_t r;
        r             = '{default: '0};
        r.smp         = s;
        r.typed       = 1'b1;
        r.want.index  = '0;
        r.want.x      = X_BITS'(x);
        r.want.peak   = SBITS'(pk);
        r.want.top    = Y_BITS'(top);
        r.want.bottom = Y_BITS'(bot);
        r.want.last   = 1'b1;
        r.want.done   = 1'b1;
        dir_rows.push_back(r);
    endtask

    always @(posedge clk) out_stall <= !quiet && ($urandom_range(0, 99) < 24);

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk) begin : check_lines
        line_word_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_lines.size() == 0) begin
                $error("line word with nothing expected: line_index %0d", line_index);
                errors++;
            end else begin
                want = pending_lines.pop_front();
                check_field("line_index", want.index, line_index);
                check_field("line_x", want.x, line_x);
                check_field("peak", want.peak, peak);
                check_field("y_top", int'($signed(want.top)), int'(y_top));
                check_field("y_bottom", want.bottom, y_bottom);
                check_field("last_of_run", want.last, last_of_run);
                check_field("frame_done", want.done, frame_done);
            end
        end
    end

    initial begin : stimulus
        stim_row_t                 row;
        logic [CFG_DATA_BITS-1:0]  n;
        logic [LINE_BITS-1:0]      l;
        int unsigned               items, done_items, phase;

        r_num_samples = 1;
        r_num_lines   = '0;
        r_half_height = '0;
        r_center_y    = '0;
        r_x_origin    = '0;
        restart_frame();

        // no lines configured after reset
        add_sample(16'sh7FFF);
        add_cfg(CFG_NUM_LINES, 1);
        add_cfg(CFG_HALF_HEIGHT, 2047);
        add_cfg(CFG_CENTER_Y, 2048);
        add_cfg(CFG_X_ORIGIN, 4095);
        add_typed(-32768, 4095, 32768, 1, 4095);
        add_typed(32767, 4095, 32767, 2, 4094);
        add_typed(0, 4095, 0, 2048, 2048);
        add_cfg(CFG_CENTER_Y, 0);
        add_typed(-32768, 4095, 32768, -2047, 2047);
        add_cfg(CFG_CENTER_Y, 4095);
        add_typed(-1, 4095, 1, 4095, 4095);
        add_cfg(CFG_HALF_HEIGHT, 0);
        add_typed(-32768, 4095, 32768, 4095, 4095);
        // zero sample count acts as one
        add_cfg(CFG_NUM_SAMPLES, 0);
        add_cfg(CFG_X_ORIGIN, 0);
        add_cfg(CFG_HALF_HEIGHT, 1024);
        add_sample(12345);
        add_sample(-23456);
        // long runs: cap at 64 words, rest skipped
        add_cfg(CFG_NUM_LINES, 65);
        add_sample(-20000);
        add_cfg(CFG_NUM_LINES, LINES_TOP);
        add_cfg(CFG_X_ORIGIN, 4095);
        add_sample(1);
        // write to an unused index mid-frame leaves the frame alone
        add_cfg(CFG_NUM_SAMPLES, 3);
        add_cfg(CFG_NUM_LINES, 2);
        add_sample(5);
        add_cfg(CFG_SPARE_HI, CFG_DATA_ALL);
        add_sample(-7);
        add_sample(3);
        // more lines than samples
        add_cfg(CFG_NUM_SAMPLES, 2);
        add_cfg(CFG_NUM_LINES, 100);
        add_sample(-32768);
        add_sample(100);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.is_cfg) begin
                write_reg(row.idx, row.data);
            end else if (row.typed) begin
                send_sample(row.smp, 1'b0);
                pending_lines.push_back(row.want);
            end else begin
                send_sample(row.smp, 1'b1);
            end
        end

        phase      = 0;
        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            quiet = (phase == 2);
            if (phase == 1) begin
                n = $urandom_range(40, 120);
                run_phase(n, LINES_TOP, n + 3);
            end else if (phase == 3) begin
                // oversized sample count saturates: first line at sample 256
                run_phase(CFG_DATA_ALL, LINES_TOP, 260);
            end else if (phase == 4) begin
                run_phase(FRAME_CAP, LINES_TOP, 260);
            end else begin
                n = $urandom_range(0, 16);
                if ($urandom_range(0, 4) == 0) l = $urandom_range(0, 3);
                else l = $urandom_range(1, 3 * n + 2);
                items = 2 * n + $urandom_range(1, 6);
                run_phase(n, l, items);
                done_items += items;
            end
            phase++;
        end
        quiet = 1'b0;

        in_valid <= 1'b0;
        while (pending_lines.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_lines.size() != 0) begin
            $error("%0d line words never arrived", pending_lines.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
